// ===== rtl/isvs_pkg.sv =====
// Shared types and constants for the irrigation scheduler valve sweep block.
`timescale 1ns / 1ps

package isvs_pkg;

  localparam int unsigned CntW   = 20;
  localparam int unsigned MoveW  = 10;
  localparam int unsigned HumW   = 7;
  localparam int unsigned LightW = 10;
  localparam int unsigned AngleW = 8;
  localparam int unsigned IdxW   = 3;

  localparam logic [CntW-1:0]   CntMax   = {CntW{1'b1}};
  localparam logic [MoveW-1:0]  MoveMax  = {MoveW{1'b1}};
  localparam logic [AngleW-1:0] AngleTop = 8'd180;
  localparam logic [AngleW-1:0] AngleStep = 8'd2;

  localparam logic [IdxW-1:0] RegCheckInterval = 3'd0;
  localparam logic [IdxW-1:0] RegCycleDuration = 3'd1;
  localparam logic [IdxW-1:0] RegHumThreshold  = 3'd2;
  localparam logic [IdxW-1:0] RegLightThreshold = 3'd3;
  localparam logic [IdxW-1:0] RegSweepInterval = 3'd4;

  localparam logic [CntW-1:0]   CheckIntervalRst = 20'd10000;
  localparam logic [CntW-1:0]   CycleDurationRst = 20'd15000;
  localparam logic [HumW-1:0]   HumThresholdRst  = 7'd40;
  localparam logic [LightW-1:0] LightThresholdRst = 10'd200;
  localparam logic [MoveW-1:0]  SweepIntervalRst = 10'd30;

  typedef struct packed {
    logic [CntW-1:0]   check_interval;
    logic [CntW-1:0]   cycle_duration;
    logic [HumW-1:0]   hum_threshold;
    logic [LightW-1:0] light_threshold;
    logic [MoveW-1:0]  sweep_interval;
  } cfg_t;

  typedef struct packed {
    logic [HumW-1:0]   humidity;
    logic [LightW-1:0] light_level;
    logic              manual_mode;
    logic              manual_on;
    logic              manual_off;
  } tick_t;

  typedef struct packed {
    logic              valve_open;
    logic [AngleW-1:0] servo_angle;
    logic              cycle_active;
  } result_t;

endpackage

// ===== rtl/isvs_cfg.sv =====
// Configuration register file for the irrigation scheduler valve sweep block.
`timescale 1ns / 1ps

module isvs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [isvs_pkg::IdxW-1:0]   cfg_index,
  input  logic [isvs_pkg::CntW-1:0]   cfg_wdata,
  output isvs_pkg::cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_interval  <= isvs_pkg::CheckIntervalRst;
      cfg.cycle_duration  <= isvs_pkg::CycleDurationRst;
      cfg.hum_threshold   <= isvs_pkg::HumThresholdRst;
      cfg.light_threshold <= isvs_pkg::LightThresholdRst;
      cfg.sweep_interval  <= isvs_pkg::SweepIntervalRst;
    end else if (cfg_we) begin
      case (cfg_index)
        isvs_pkg::RegCheckInterval:  cfg.check_interval  <= cfg_wdata;
        isvs_pkg::RegCycleDuration:  cfg.cycle_duration  <= cfg_wdata;
        isvs_pkg::RegHumThreshold:   cfg.hum_threshold   <= cfg_wdata[isvs_pkg::HumW-1:0];
        isvs_pkg::RegLightThreshold: cfg.light_threshold <= cfg_wdata[isvs_pkg::LightW-1:0];
        isvs_pkg::RegSweepInterval:  cfg.sweep_interval  <= cfg_wdata[isvs_pkg::MoveW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/isvs_ctrl.sv =====
// Scheduler and servo sweep state with its one-tick update logic.
`timescale 1ns / 1ps

module isvs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  isvs_pkg::tick_t    tick,
  input  isvs_pkg::cfg_t     cfg,
  output isvs_pkg::result_t  result_next
);

  logic [isvs_pkg::CntW-1:0]   since_check, since_check_next;
  logic [isvs_pkg::CntW-1:0]   since_cycle_start, since_cycle_start_next;
  logic                        window_active, window_active_next;
  logic                        irrigating, irrigating_next;
  logic [isvs_pkg::AngleW-1:0] angle, angle_next;
  logic                        sweeping_down, sweeping_down_next;
  logic [isvs_pkg::MoveW-1:0]  since_move, since_move_next;
  logic [isvs_pkg::AngleW:0]   angle_up;

  assign angle_up = {1'b0, angle} + {1'b0, isvs_pkg::AngleStep};

  always_comb begin
    since_check_next = (since_check == isvs_pkg::CntMax) ? since_check
                                                         : since_check + 1'b1;
    since_cycle_start_next = (since_cycle_start == isvs_pkg::CntMax) ? since_cycle_start
                                                                     : since_cycle_start + 1'b1;
    since_move_next = (since_move == isvs_pkg::MoveMax) ? since_move : since_move + 1'b1;
    window_active_next = window_active;
    irrigating_next    = irrigating;
    angle_next         = angle;
    sweeping_down_next = sweeping_down;

    if (tick.manual_mode) begin
      if (tick.manual_on) begin
        irrigating_next    = 1'b1;
        window_active_next = 1'b0;
      end else if (tick.manual_off) begin
        irrigating_next        = 1'b0;
        window_active_next     = 1'b0;
        angle_next             = '0;
        since_cycle_start_next = '0;
      end
    end else if (since_check_next >= cfg.check_interval) begin
      since_check_next = '0;
      if (!window_active) begin
        if (tick.humidity < cfg.hum_threshold && tick.light_level < cfg.light_threshold) begin
          irrigating_next        = 1'b1;
          window_active_next     = 1'b1;
          since_cycle_start_next = '0;
        end
      end else if (since_cycle_start_next >= cfg.cycle_duration) begin
        irrigating_next        = 1'b0;
        window_active_next     = 1'b0;
        angle_next             = '0;
        since_cycle_start_next = '0;
      end
    end

    if (irrigating_next && since_move_next >= cfg.sweep_interval) begin
      since_move_next = '0;
      if (!sweeping_down) begin
        if (angle_up >= {1'b0, isvs_pkg::AngleTop}) begin
          angle_next         = isvs_pkg::AngleTop;
          sweeping_down_next = 1'b1;
        end else begin
          angle_next = angle_up[isvs_pkg::AngleW-1:0];
        end
      end else if (angle_next <= isvs_pkg::AngleStep) begin
        angle_next         = '0;
        sweeping_down_next = 1'b0;
      end else begin
        angle_next = angle_next - isvs_pkg::AngleStep;
      end
    end

    result_next.valve_open   = irrigating_next;
    result_next.servo_angle  = angle_next;
    result_next.cycle_active = window_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_check       <= '0;
      since_cycle_start <= '0;
      window_active     <= 1'b0;
      irrigating        <= 1'b0;
      angle             <= '0;
      sweeping_down     <= 1'b0;
      since_move        <= '0;
    end else if (step) begin
      since_check       <= since_check_next;
      since_cycle_start <= since_cycle_start_next;
      window_active     <= window_active_next;
      irrigating        <= irrigating_next;
      angle             <= angle_next;
      sweeping_down     <= sweeping_down_next;
      since_move        <= since_move_next;
    end
  end

endmodule

// ===== rtl/irrigation_scheduler_valve_sweep.sv =====
// Top level of the irrigation scheduler valve sweep block.
`timescale 1ns / 1ps

// Usage:
// Each input beat is one millisecond tick carrying humidity, light_level and
// the manual_mode, manual_on, manual_off switches. Every accepted tick yields
// exactly one output beat with valve_open, servo_angle and cycle_active as
// they stand after that tick.
// The tick lands in an input register; the state update runs when the output
// register can take its result, which is captured there. A result is offered
// after both registers; one tick is taken every cycle while out_ready stays high.
// The output register sits apart from the input register, so a new tick is
// taken while a result waits; when the receiver holds out_ready low, both
// registers fill and in_ready drops until the result beat moves.
// Configuration registers are written through cfg_we, cfg_index, cfg_wdata
// (index 0 check interval, 1 cycle duration, 2 humidity threshold, 3 light
// threshold, 4 sweep interval); write them only while the block is idle.
// Reset clears the valid flags of both registers, all counters and the sweep
// state, and loads the default configuration.

module irrigation_scheduler_valve_sweep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [isvs_pkg::IdxW-1:0]     cfg_index,
  input  logic [isvs_pkg::CntW-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [isvs_pkg::HumW-1:0]     humidity,
  input  logic [isvs_pkg::LightW-1:0]   light_level,
  input  logic                          manual_mode,
  input  logic                          manual_on,
  input  logic                          manual_off,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          valve_open,
  output logic [isvs_pkg::AngleW-1:0]   servo_angle,
  output logic                          cycle_active
);

  isvs_pkg::cfg_t    cfg;
  isvs_pkg::tick_t   tick;
  isvs_pkg::result_t result, result_next;
  logic              tick_valid;
  logic              step;

  assign step     = tick_valid && (!out_valid || out_ready);
  assign in_ready = !tick_valid || step;

  isvs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  isvs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .tick        (tick),
    .cfg         (cfg),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (in_ready) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tick.humidity    <= humidity;
      tick.light_level <= light_level;
      tick.manual_mode <= manual_mode;
      tick.manual_on   <= manual_on;
      tick.manual_off  <= manual_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

  assign valve_open   = result.valve_open;
  assign servo_angle  = result.servo_angle;
  assign cycle_active = result.cycle_active;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the irrigation scheduler valve sweep block.
`timescale 1ns / 1ps

module testbench;

  localparam int QuietLimit     = 3000;
  localparam int HoldCycles     = 300;
  localparam int PressureAtBeat = 150;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [isvs_pkg::IdxW-1:0]     cfg_index = '0;
  logic [isvs_pkg::CntW-1:0]     cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [isvs_pkg::HumW-1:0]     humidity = '0;
  logic [isvs_pkg::LightW-1:0]   light_level = '0;
  logic                          manual_mode = 1'b0;
  logic                          manual_on = 1'b0;
  logic                          manual_off = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          valve_open;
  logic [isvs_pkg::AngleW-1:0]   servo_angle;
  logic                          cycle_active;

  irrigation_scheduler_valve_sweep dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .humidity    (humidity),
    .light_level (light_level),
    .manual_mode (manual_mode),
    .manual_on   (manual_on),
    .manual_off  (manual_off),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .valve_open  (valve_open),
    .servo_angle (servo_angle),
    .cycle_active(cycle_active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scheduler configuration and state as the block should hold them.
  isvs_pkg::cfg_t valve_cfg = '{check_interval:  isvs_pkg::CheckIntervalRst,
                                cycle_duration:  isvs_pkg::CycleDurationRst,
                                hum_threshold:   isvs_pkg::HumThresholdRst,
                                light_threshold: isvs_pkg::LightThresholdRst,
                                sweep_interval:  isvs_pkg::SweepIntervalRst};
  logic [isvs_pkg::CntW-1:0]   since_check = '0;
  logic [isvs_pkg::CntW-1:0]   since_start = '0;
  logic                        window_on = 1'b0;
  logic                        irrigating = 1'b0;
  logic [isvs_pkg::AngleW-1:0] angle = '0;
  logic                        sweep_down = 1'b0;
  logic [isvs_pkg::MoveW-1:0]  since_move = '0;

  isvs_pkg::tick_t   tick_q[$];
  isvs_pkg::result_t result_q[$];
  int      mismatches = 0;
  int      in_beats = 0;
  int      out_beats = 0;
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;
  int      mode_sel = 0;
  int      quiet = 0;
  int      hold_left = 0;
  logic    pressure_done = 1'b0;

  function automatic void close_valve();
    irrigating  = 1'b0;
    angle       = '0;
    window_on   = 1'b0;
    since_start = '0;
  endfunction

  function automatic isvs_pkg::result_t advance_tick(isvs_pkg::tick_t t);
    isvs_pkg::result_t r;
    int      next_angle;
    since_check = (since_check == isvs_pkg::CntMax) ? isvs_pkg::CntMax : since_check + 1'b1;
    since_start = (since_start == isvs_pkg::CntMax) ? isvs_pkg::CntMax : since_start + 1'b1;
    since_move  = (since_move == isvs_pkg::MoveMax) ? isvs_pkg::MoveMax : since_move + 1'b1;
    if (t.manual_mode) begin
      if (t.manual_on) begin
        irrigating = 1'b1;
        window_on  = 1'b0;
      end else if (t.manual_off) begin
        close_valve();
      end
    end else if (since_check >= valve_cfg.check_interval) begin
      since_check = '0;
      if (!window_on) begin
        if (t.humidity < valve_cfg.hum_threshold &&
            t.light_level < valve_cfg.light_threshold) begin
          irrigating  = 1'b1;
          window_on   = 1'b1;
          since_start = '0;
        end
      end else if (since_start >= valve_cfg.cycle_duration) begin
        close_valve();
      end
    end
    if (irrigating && since_move >= valve_cfg.sweep_interval) begin
      since_move = '0;
      next_angle = int'(angle) + (sweep_down ? -int'(isvs_pkg::AngleStep)
                                             : int'(isvs_pkg::AngleStep));
      if (next_angle >= int'(isvs_pkg::AngleTop)) begin
        next_angle = int'(isvs_pkg::AngleTop);
        sweep_down = 1'b1;
      end else if (next_angle <= 0) begin
        next_angle = 0;
        sweep_down = 1'b0;
      end
      angle = next_angle[isvs_pkg::AngleW-1:0];
    end
    r.valve_open   = irrigating;
    r.servo_angle  = angle;
    r.cycle_active = window_on;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("result %0d: %s", out_beats, what);
    mismatches++;
  endtask

  // Driver: hold the beat until it is taken, then advance.
  always @(posedge clk) begin : drive_ticks
    isvs_pkg::tick_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        cur = tick_q.pop_front();
        in_valid    <= 1'b1;
        humidity    <= cur.humidity;
        light_level <= cur.light_level;
        manual_mode <= cur.manual_mode;
        manual_on   <= cur.manual_on;
        manual_off  <= cur.manual_off;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the pipe.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!pressure_done && in_beats >= PressureAtBeat) begin
      pressure_done <= 1'b1;
      hold_left     <= HoldCycles;
      out_ready     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: predict on each input beat, check each result beat.
  always @(posedge clk) begin : watch_beats
    isvs_pkg::result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        result_q.push_back(advance_tick({humidity, light_level, manual_mode,
                                         manual_on, manual_off}));
        in_beats++;
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = result_q.pop_front();
          if (valve_open !== want.valve_open)
            report_mismatch($sformatf("valve_open %b, expected %b",
                                      valve_open, want.valve_open));
          if (servo_angle !== want.servo_angle)
            report_mismatch($sformatf("servo_angle %0d, expected %0d",
                                      servo_angle, want.servo_angle));
          if (cycle_active !== want.cycle_active)
            report_mismatch($sformatf("cycle_active %b, expected %b",
                                      cycle_active, want.cycle_active));
        end
        out_beats++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("timeout: no beat for %0d cycles", quiet);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_tick(int hum, int light, bit mode, bit on, bit off);
    isvs_pkg::tick_t t;
    t.humidity    = hum[isvs_pkg::HumW-1:0];
    t.light_level = light[isvs_pkg::LightW-1:0];
    t.manual_mode = mode;
    t.manual_on   = on;
    t.manual_off  = off;
    tick_q.push_back(t);
  endtask

  // Mostly coherent sessions: automatic runs and manual open/hold/close,
  // with some fully random ticks mixed in.
  task automatic push_sessions(int n);
    isvs_pkg::tick_t t;
    int    left;
    int    len;
    int    kind;
    int    rnd;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(9);
      len  = $urandom_range(4, 40);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        rnd = $urandom_range(1) ? $urandom_range(127)
                                : $urandom_range(valve_cfg.hum_threshold);
        t.humidity    = rnd[isvs_pkg::HumW-1:0];
        rnd = $urandom_range(1) ? $urandom_range(1023)
                                : $urandom_range(valve_cfg.light_threshold);
        t.light_level = rnd[isvs_pkg::LightW-1:0];
        if (kind <= 4) begin
          t.manual_mode = 1'b0;
          t.manual_on   = ($urandom_range(1) != 0);
          t.manual_off  = ($urandom_range(1) != 0);
        end else if (kind <= 7) begin
          t.manual_mode = 1'b1;
          t.manual_on   = (i == 0) || ($urandom_range(19) == 0);
          t.manual_off  = (i == len - 1) ? ($urandom_range(2) == 0)
                                         : ($urandom_range(19) == 0);
        end else begin
          t.manual_mode = ($urandom_range(1) != 0);
          t.manual_on   = ($urandom_range(1) != 0);
          t.manual_off  = ($urandom_range(1) != 0);
        end
        tick_q.push_back(t);
      end
      left -= len;
    end
  endtask

  task automatic write_reg(logic [isvs_pkg::IdxW-1:0] idx, logic [isvs_pkg::CntW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      isvs_pkg::RegCheckInterval:  valve_cfg.check_interval  = data;
      isvs_pkg::RegCycleDuration:  valve_cfg.cycle_duration  = data;
      isvs_pkg::RegHumThreshold:   valve_cfg.hum_threshold   = data[isvs_pkg::HumW-1:0];
      isvs_pkg::RegLightThreshold: valve_cfg.light_threshold = data[isvs_pkg::LightW-1:0];
      isvs_pkg::RegSweepInterval:  valve_cfg.sweep_interval  = data[isvs_pkg::MoveW-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Narrow registers get junk in the unused upper bits of the write data.
  task automatic set_config(logic [isvs_pkg::CntW-1:0] check,
                            logic [isvs_pkg::CntW-1:0] duration,
                            logic [isvs_pkg::HumW-1:0] hum,
                            logic [isvs_pkg::LightW-1:0] light,
                            logic [isvs_pkg::MoveW-1:0] sweep);
    logic [isvs_pkg::CntW-1:0] data;
    int rnd;
    write_reg(isvs_pkg::RegCheckInterval, check);
    write_reg(isvs_pkg::RegCycleDuration, duration);
    rnd = $urandom;
    data = rnd[isvs_pkg::CntW-1:0];
    data[isvs_pkg::HumW-1:0] = hum;
    write_reg(isvs_pkg::RegHumThreshold, data);
    rnd = $urandom;
    data = rnd[isvs_pkg::CntW-1:0];
    data[isvs_pkg::LightW-1:0] = light;
    write_reg(isvs_pkg::RegLightThreshold, data);
    rnd = $urandom;
    data = rnd[isvs_pkg::CntW-1:0];
    data[isvs_pkg::MoveW-1:0] = sweep;
    write_reg(isvs_pkg::RegSweepInterval, data);
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Cycle through: no idling, sender idle, receiver stalling, both.
  task automatic random_phase(int n);
    int left;
    int chunk;
    left = n;
    while (left > 0) begin
      chunk = (left > 100) ? 100 : left;
      case (mode_sel % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      mode_sel++;
      push_sessions(chunk);
      wait_drained();
      left -= chunk;
    end
  endtask

  initial begin
    int junk;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    push_tick(0, 0, 0, 0, 0);
    push_tick(100, 1023, 0, 1, 1);
    push_tick(127, 1023, 1, 0, 0);
    push_tick(50, 300, 1, 1, 0);
    push_tick(0, 0, 1, 1, 1);
    push_tick(0, 0, 1, 0, 1);
    wait_drained();

    set_config('0, '0, 7'd100, 10'd1023, '0);
    for (int i = isvs_pkg::RegSweepInterval + 1; i < (1 << isvs_pkg::IdxW); i++) begin
      junk = $urandom;
      write_reg(i[isvs_pkg::IdxW-1:0], junk[isvs_pkg::CntW-1:0]);
    end
    push_tick(0, 0, 0, 0, 0);
    push_tick(0, 0, 0, 0, 0);
    push_tick(100, 0, 0, 0, 0);
    push_tick(0, 1023, 0, 0, 0);
    push_tick(99, 1022, 0, 0, 0);
    push_tick(10, 10, 1, 1, 0);
    push_tick(127, 1023, 1, 0, 0);
    push_tick(64, 512, 1, 0, 0);
    push_tick(1, 1, 1, 0, 0);
    push_tick(0, 0, 1, 0, 1);
    push_tick(0, 0, 1, 1, 0);
    push_tick(0, 0, 0, 0, 0);
    push_tick(127, 1023, 0, 1, 1);
    push_tick(0, 0, 0, 0, 0);
    push_tick(0, 0, 1, 0, 1);
    push_tick(85, 341, 0, 0, 0);
    wait_drained();
    random_phase(100);

    set_config(20'd3, 20'd7, 7'd50, 10'd500, 10'd2);
    random_phase(250);

    // Cycles never time out here, so the servo runs its full sweep.
    set_config(20'd1, isvs_pkg::CntMax, 7'd127, 10'd1023, 10'd1);
    random_phase(200);

    // Longest intervals: the scheduler stays idle and the servo rarely moves.
    set_config(isvs_pkg::CntMax, 20'd1, 7'd0, 10'd0, isvs_pkg::MoveMax);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    push_tick(0, 0, 1, 0, 1);
    push_tick(30, 30, 1, 1, 0);
    push_tick(30, 30, 1, 0, 0);
    wait_drained();
    random_phase(60);

    set_config(20'd5, 20'd20, 7'd40, 10'd200, 10'd3);
    random_phase(165);

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/isvs_pkg.sv
rtl/isvs_cfg.sv
rtl/isvs_ctrl.sv
rtl/irrigation_scheduler_valve_sweep.sv
dv/testbench.sv
